[design/assert_macros.svh]
// Assertion macros for the RTL files; only the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst, prop) \
    lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("lbl failed");
`define ASSERT_NEXT(lbl, clk, rst, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error("lbl failed");
`else
`define ASSERT_IMPL(lbl, clk, rst, prop)
`define ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

[design/rla_pkg.sv]
// Package for the running LCM accumulator: sequencer states and unit commands.
`default_nettype none
package rla_pkg;
    typedef enum logic [3:0] {
        S_IDLE, S_GCD_START, S_GCD_WAIT, S_Q_START, S_Q_WAIT,
        S_M_START, S_M_WAIT, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        OP_MOD = 2'd0,
        OP_DIV = 2'd1,
        OP_MUL = 2'd2
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_unit_ctl;
endpackage
`default_nettype wire

[design/rla_alu.sv]
// Shared bit-serial unit: restoring divide (quotient or remainder) and shift-add multiply.
`default_nettype none
module rla_alu
    import rla_pkg::*;
#(
    parameter int W = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_unit_ctl    i_ctl,
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    output logic              o_busy,
    output logic              o_done,
    output logic [W-1:0]      o_res,
    output logic              o_ovf
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_a, n_a;
    logic [W-1:0]  r_b, n_b;
    logic [W-1:0]  r_acc, n_acc;
    logic          r_ovf, n_ovf;
    t_op           r_op, n_op;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [W:0]    w_trial;
    logic [W:0]    w_sum;

    // one step per cycle
    always_comb begin
        n_a = r_a; n_b = r_b; n_acc = r_acc; n_ovf = r_ovf; n_op = r_op;
        n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        w_trial = '0; w_sum = '0;
        if (i_ctl.start) begin
            n_a = i_a; n_b = i_b; n_acc = '0; n_ovf = 1'b0; n_op = i_ctl.op;
            n_cnt = CW'(W); n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_op == OP_MUL) begin
                // a shifts right, b shifts left; overflow on an add carry or if a set bit meets a lost b
                w_sum = {1'b0, r_acc} + {1'b0, r_b};
                if (r_a[0]) begin
                    n_acc = w_sum[W-1:0];
                    if (w_sum[W]) n_ovf = 1'b1;
                end
                if (r_a[W-1:1] != '0 && r_b[W-1]) n_ovf = 1'b1;
                n_a = r_a >> 1;
                n_b = r_b << 1;
            end else begin
                // remainder in acc, dividend shifts out of a, quotient into a
                w_trial = {r_acc, r_a[W-1]} - {1'b0, r_b};
                if (!w_trial[W]) begin
                    n_acc = w_trial[W-1:0];
                    n_a = {r_a[W-2:0], 1'b1};
                end else begin
                    n_acc = {r_acc[W-2:0], r_a[W-1]};
                    n_a = {r_a[W-2:0], 1'b0};
                end
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_a <= n_a; r_b <= n_b; r_acc <= n_acc; r_ovf <= n_ovf; r_op <= n_op;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_res  = (r_op == OP_DIV) ? r_a : r_acc;
    assign o_ovf  = r_ovf;
endmodule
`default_nettype wire

[design/running_lcm_accumulator.sv]
// Top level of the running LCM accumulator: sequencer around one shared unit.
//  channel | dir | handshake              | payload
//  s_axis  | in  | tvalid/tready          | tdata=value, tuser=first
//  m_axis  | out | tvalid/tready          | tdata=lcm, tuser=overflow
// For first, saturated or zero cases an item goes from the accept straight to the result beat;
// otherwise the W-bit unit (W the larger of VALUE_BITS and ACC_BITS) runs each Euclid
// remainder step, then the final zero check is made, then the divide and the multiply run,
// between the accept and the result.
// Rate is set by the bit-serial shared divide/multiply unit.
// Reset clears the state, accumulator and overflow flag. Ready is low while an item is
// being worked or its result waits; a stalled result holds.
`default_nettype none
`include "assert_macros.svh"
module running_lcm_accumulator
    import rla_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int ACC_BITS   = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // value
    input  wire logic [((VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // first
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // lcm
    output logic [((ACC_BITS+7)/8)*8-1:0] m_axis_tdata,
    // overflow
    output logic                       m_axis_tuser
);
    localparam int W = (VALUE_BITS > ACC_BITS) ? VALUE_BITS : ACC_BITS;
    localparam int OW = ((ACC_BITS+7)/8)*8;
    localparam logic [W-1:0] ACC_MASK = W'({ACC_BITS{1'b1}});

    t_state        r_state, n_state;
    logic [W-1:0]  r_acc, n_acc;
    logic          r_ovf, n_ovf;
    logic [W-1:0]  r_x, n_x;
    logic [W-1:0]  r_y, n_y;
    logic [W-1:0]  r_v, n_v;
    t_unit_ctl     w_ctl;
    logic [W-1:0]  w_ua, w_ub;
    logic          w_busy, w_done, w_uovf;
    logic [W-1:0]  w_res;
    logic [W-1:0]  w_val;

    assign w_val = W'(s_axis_tdata[VALUE_BITS-1:0]);

    rla_alu #(.W(W)) u_alu (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl), .i_a(w_ua), .i_b(w_ub),
        .o_busy(w_busy), .o_done(w_done), .o_res(w_res), .o_ovf(w_uovf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_acc   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_ovf   <= n_ovf;
        end
        r_x <= n_x; r_y <= n_y; r_v <= n_v;
    end

    // sequencer
    always_comb begin
        n_state = r_state; n_acc = r_acc; n_ovf = r_ovf;
        n_x = r_x; n_y = r_y; n_v = r_v;
        w_ctl = '{start: 1'b0, op: OP_MOD};
        w_ua = r_x; w_ub = r_y;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_v = w_val;
                    if (s_axis_tuser) begin
                        n_ovf = 1'b0;
                        if (w_val > ACC_MASK) begin
                            n_ovf = 1'b1; n_acc = ACC_MASK;
                        end else n_acc = w_val;
                        n_state = S_OUT;
                    end else if (r_ovf) begin
                        n_acc = ACC_MASK; n_state = S_OUT;
                    end else if (w_val == '0 || r_acc == '0) begin
                        n_acc = '0; n_state = S_OUT;
                    end else begin
                        n_x = r_acc; n_y = w_val; n_state = S_GCD_START;
                    end
                end
            end
            S_GCD_START: begin
                if (r_y == '0) n_state = S_Q_START;
                else begin
                    w_ctl = '{start: 1'b1, op: OP_MOD};
                    n_state = S_GCD_WAIT;
                end
            end
            S_GCD_WAIT: if (w_done) begin
                n_x = r_y; n_y = w_res; n_state = S_GCD_START;
            end
            S_Q_START: begin
                w_ua = r_acc; w_ub = r_x;
                w_ctl = '{start: 1'b1, op: OP_DIV};
                n_state = S_Q_WAIT;
            end
            S_Q_WAIT: if (w_done) begin
                n_x = w_res; n_state = S_M_START;
            end
            S_M_START: begin
                w_ua = r_x; w_ub = r_v;
                w_ctl = '{start: 1'b1, op: OP_MUL};
                n_state = S_M_WAIT;
            end
            S_M_WAIT: if (w_done) begin
                if (w_uovf || w_res > ACC_MASK) begin
                    n_ovf = 1'b1; n_acc = ACC_MASK;
                end else n_acc = w_res;
                n_state = S_OUT;
            end
            S_OUT: if (m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = OW'(r_acc[ACC_BITS-1:0]);
    assign m_axis_tuser  = r_ovf;

    `ASSERT_IMPL(a_sat, i_clk, !i_rst_n, !(m_axis_tvalid && m_axis_tuser) || r_acc == ACC_MASK)
    `ASSERT_IMPL(a_excl, i_clk, !i_rst_n, !(s_axis_tready && m_axis_tvalid))
    `ASSERT_IMPL(a_wait_busy, i_clk, !i_rst_n, !(r_state == S_Q_WAIT && !w_busy && !w_done))
    `ASSERT_NEXT(a_hold, i_clk, !i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule
`default_nettype wire
